// ===== hdl/alarm_set_and_trigger_top_macros.svh =====
// ----------------------------------------------------------------------------
// alarm set and trigger assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ALARM_SET_AND_TRIGGER_TOP_MACROS_SVH
`define ALARM_SET_AND_TRIGGER_TOP_MACROS_SVH

// same-cycle implication
`define AST_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("assertion failed");

// next-cycle implication
`define AST_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("assertion failed");

`endif

// ===== hdl/ast_pkg.sv =====
// ----------------------------------------------------------------------------
// ast_pkg
// types and constants shared by the alarm set and trigger block
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int BeatW   = 4;

  localparam logic [HourW-1:0]   HourMax24  = 5'd23;
  localparam logic [HourW-1:0]   HourMax12  = 5'd12;
  localparam logic [MinuteW-1:0] MinuteMax  = 6'd59;
  localparam logic [BeatW-1:0]   BeatMax    = 4'd15;
  localparam logic [BeatW-1:0]   BeatLimitReset = 4'd6;

  typedef enum logic {
    OP_EDITOR = 1'b0,
    OP_ALARM  = 1'b1
  } op_t;

  typedef enum logic {
    CFG_HOUR_MODE  = 1'b0,
    CFG_BEAT_LIMIT = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    E_INIT     = 4'd0,
    E_WAIT     = 4'd1,
    E_BWAIT    = 4'd2,
    E_COMMIT   = 4'd3,
    E_CANCEL   = 4'd4,
    E_SHOW_H   = 4'd5,
    E_FIELD_H  = 4'd6,
    E_INC_H    = 4'd7,
    E_DEC_H    = 4'd8,
    E_SHOW_M   = 4'd9,
    E_FIELD_M  = 4'd10,
    E_INC_M    = 4'd11,
    E_DEC_M    = 4'd12,
    E_SHOW_P   = 4'd13,
    E_FIELD_P  = 4'd14,
    E_TOGGLE_P = 4'd15
  } editor_state_t;

  typedef enum logic [2:0] {
    P_INIT = 3'd0,
    P_WAIT = 3'd1,
    P_ON   = 3'd2,
    P_OFF  = 3'd3,
    P_STOP = 3'd4
  } pattern_state_t;

  typedef struct packed {
    logic left;
    logic right;
    logic up;
    logic down;
    logic req;
  } buttons_t;

  typedef struct packed {
    editor_state_t      state;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic               pm;
  } edit_t;

  typedef struct packed {
    logic               flag;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic               pm;
  } armed_t;

  typedef struct packed {
    pattern_state_t   state;
    logic [BeatW-1:0] beat;
  } pattern_t;

  typedef struct packed {
    op_t                op;
    buttons_t           buttons;
    logic               heartbeat;
    logic [HourW-1:0]   clock_hour;
    logic [MinuteW-1:0] clock_minute;
  } tick_t;

endpackage

// ===== hdl/ast_if.sv =====
// ----------------------------------------------------------------------------
// ast channels
// valid/ready interfaces for the tick input and the result output
// ----------------------------------------------------------------------------
interface ast_tick_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic       left_pressed;
  logic       right_pressed;
  logic       up_pressed;
  logic       down_pressed;
  logic       edit_request;
  logic       heartbeat;
  logic [4:0] clock_hour;
  logic [5:0] clock_minute;

  modport source (output valid, operation, left_pressed, right_pressed, up_pressed,
                  down_pressed, edit_request, heartbeat, clock_hour, clock_minute,
                  input ready);
  modport sink (input valid, operation, left_pressed, right_pressed, up_pressed,
                down_pressed, edit_request, heartbeat, clock_hour, clock_minute,
                output ready);
endinterface

interface ast_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] editor_phase;
  logic [4:0] edit_hour;
  logic [5:0] edit_minute;
  logic       edit_pm;
  logic       alarm_armed;
  logic [4:0] armed_hour;
  logic [5:0] armed_minute;
  logic       armed_pm;
  logic       buzzer_on;
  logic       committed;
  logic       cancelled;

  modport source (output valid, editor_phase, edit_hour, edit_minute, edit_pm,
                  alarm_armed, armed_hour, armed_minute, armed_pm, buzzer_on,
                  committed, cancelled, input ready);
  modport sink (input valid, editor_phase, edit_hour, edit_minute, edit_pm,
                alarm_armed, armed_hour, armed_minute, armed_pm, buzzer_on,
                committed, cancelled, output ready);
endinterface

// ===== hdl/ast_editor.sv =====
// ----------------------------------------------------------------------------
// ast_editor
// next-state logic of the alarm edit state machine and the edited time
// ----------------------------------------------------------------------------
module ast_editor (
  input  ast_pkg::edit_t    cur,
  input  ast_pkg::buttons_t buttons,
  input  logic              hour_mode,
  output ast_pkg::edit_t    nxt
);

  logic                        only_l, only_r, only_u, only_d;
  ast_pkg::editor_state_t      n;
  logic [ast_pkg::HourW-1:0]   hour_inc;
  logic [ast_pkg::MinuteW-1:0] minute_inc;

  assign only_l = buttons.left  & ~buttons.right & ~buttons.up    & ~buttons.down;
  assign only_r = buttons.right & ~buttons.left  & ~buttons.up    & ~buttons.down;
  assign only_u = buttons.up    & ~buttons.left  & ~buttons.right & ~buttons.down;
  assign only_d = buttons.down  & ~buttons.left  & ~buttons.right & ~buttons.up;

  assign hour_inc   = cur.hour + 5'd1;
  assign minute_inc = cur.minute + 6'd1;

  always_comb begin
    unique case (cur.state)
      ast_pkg::E_INIT:   n = ast_pkg::E_WAIT;
      ast_pkg::E_WAIT:   n = buttons.req ? ast_pkg::E_BWAIT : ast_pkg::E_WAIT;
      ast_pkg::E_BWAIT:  n = (buttons.left | buttons.right) ? ast_pkg::E_BWAIT
                                                            : ast_pkg::E_FIELD_H;
      ast_pkg::E_SHOW_H: n = ast_pkg::E_FIELD_H;
      ast_pkg::E_FIELD_H: begin
        if (only_l)      n = ast_pkg::E_SHOW_M;
        else if (only_r) n = ast_pkg::E_CANCEL;
        else if (only_u) n = ast_pkg::E_INC_H;
        else if (only_d) n = ast_pkg::E_DEC_H;
        else             n = cur.state;
      end
      ast_pkg::E_INC_H, ast_pkg::E_DEC_H: n = ast_pkg::E_SHOW_H;
      ast_pkg::E_SHOW_M: n = ast_pkg::E_FIELD_M;
      ast_pkg::E_FIELD_M: begin
        // 24h mode has no am/pm field, so left commits directly
        if (only_l)      n = hour_mode ? ast_pkg::E_COMMIT : ast_pkg::E_SHOW_P;
        else if (only_r) n = ast_pkg::E_SHOW_H;
        else if (only_u) n = ast_pkg::E_INC_M;
        else if (only_d) n = ast_pkg::E_DEC_M;
        else             n = cur.state;
      end
      ast_pkg::E_INC_M, ast_pkg::E_DEC_M: n = ast_pkg::E_SHOW_M;
      ast_pkg::E_SHOW_P: n = ast_pkg::E_FIELD_P;
      ast_pkg::E_FIELD_P: begin
        if (only_l)      n = ast_pkg::E_COMMIT;
        else if (only_r) n = ast_pkg::E_SHOW_M;
        else if ((buttons.up | buttons.down) & ~buttons.left & ~buttons.right)
                         n = ast_pkg::E_TOGGLE_P;
        else             n = ast_pkg::E_FIELD_P;
      end
      ast_pkg::E_TOGGLE_P: n = ast_pkg::E_SHOW_P;
      ast_pkg::E_COMMIT, ast_pkg::E_CANCEL: n = ast_pkg::E_WAIT;
      default: n = ast_pkg::E_WAIT;
    endcase
  end

  always_comb begin
    nxt       = cur;
    nxt.state = n;
    case (n)
      ast_pkg::E_BWAIT: begin
        nxt.hour   = ast_pkg::HourMax12;
        nxt.minute = '0;
        nxt.pm     = 1'b0;
      end
      ast_pkg::E_INC_H: begin
        if (hour_mode) begin
          nxt.hour = (hour_inc > ast_pkg::HourMax24) ? 5'd0 : hour_inc;
        end else begin
          nxt.hour = (hour_inc > ast_pkg::HourMax12) ? 5'd1 : hour_inc;
        end
      end
      ast_pkg::E_DEC_H: begin
        if (hour_mode && cur.hour == 5'd0)       nxt.hour = ast_pkg::HourMax24;
        else if (!hour_mode && cur.hour <= 5'd1) nxt.hour = ast_pkg::HourMax12;
        else                                     nxt.hour = cur.hour - 5'd1;
      end
      ast_pkg::E_INC_M: begin
        nxt.minute = (minute_inc > ast_pkg::MinuteMax) ? 6'd0 : minute_inc;
      end
      ast_pkg::E_DEC_M: begin
        nxt.minute = (cur.minute == 6'd0) ? ast_pkg::MinuteMax : cur.minute - 6'd1;
      end
      ast_pkg::E_TOGGLE_P: nxt.pm = ~cur.pm;
      default: ;
    endcase
  end

endmodule

// ===== hdl/ast_pattern.sv =====
// ----------------------------------------------------------------------------
// ast_pattern
// next-state logic of the alarm match and buzzer pattern
// ----------------------------------------------------------------------------
module ast_pattern (
  input  ast_pkg::pattern_t                cur,
  input  ast_pkg::armed_t                  armed,
  input  logic                             heartbeat,
  input  logic [ast_pkg::HourW-1:0]        clock_hour,
  input  logic [ast_pkg::MinuteW-1:0]      clock_minute,
  input  logic [ast_pkg::BeatW-1:0]        beat_limit,
  output ast_pkg::pattern_t                nxt,
  output logic                             disarm
);

  logic [ast_pkg::BeatW-1:0] beat_inc;

  // saturating beat count
  assign beat_inc = (heartbeat && cur.beat < ast_pkg::BeatMax) ? cur.beat + 4'd1
                                                               : cur.beat;

  always_comb begin
    nxt = cur;
    unique case (cur.state)
      ast_pkg::P_INIT: nxt.state = ast_pkg::P_WAIT;
      ast_pkg::P_WAIT: begin
        // half of day is not compared
        if (armed.flag && armed.hour == clock_hour && armed.minute == clock_minute) begin
          nxt.state = ast_pkg::P_ON;
          nxt.beat  = '0;
        end
      end
      ast_pkg::P_ON, ast_pkg::P_OFF: begin
        nxt.beat = beat_inc;
        if (beat_inc > beat_limit)          nxt.state = ast_pkg::P_STOP;
        else if (cur.state == ast_pkg::P_ON) nxt.state = ast_pkg::P_OFF;
        else                                nxt.state = ast_pkg::P_ON;
      end
      default: nxt.state = ast_pkg::P_INIT;
    endcase
  end

  assign disarm = (nxt.state == ast_pkg::P_STOP);

endmodule

// ===== hdl/alarm_set_and_trigger_top.sv =====
// ----------------------------------------------------------------------------
// alarm_set_and_trigger_top
// alarm time editor and buzzer pattern, one result item per tick item
// ----------------------------------------------------------------------------
//   channel   role    handshake     payload
//   tick      sink    valid/ready   operation, buttons, edit_request, heartbeat, clock
//   result    source  valid/ready   edit time, armed time, buzzer, commit/cancel
//   cfg       write   cfg_we        cfg_index, cfg_data (hour_mode, beat_limit)
//
// an item passes through the tick register and then the result register,
// and one item is accepted every cycle while results drain
// the state update of a tick is a single pass through the editor or the pattern logic
// result stall holds the result register; the tick register fills and then ready drops
// rst is synchronous; it clears both stages and the state machines and resets the config
module alarm_set_and_trigger_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [3:0]          cfg_data,
  ast_tick_if.sink            tick,
  ast_result_if.source        result
);

  logic                       hour_mode;
  logic [ast_pkg::BeatW-1:0]  beat_limit;

  logic                       tick_valid;
  ast_pkg::tick_t             tick_q;
  logic                       advance;

  ast_pkg::edit_t             edit;
  ast_pkg::edit_t             edit_next;
  ast_pkg::armed_t            armed;
  ast_pkg::armed_t            armed_next;
  ast_pkg::pattern_t          pattern;
  ast_pkg::pattern_t          pattern_next;
  ast_pkg::edit_t             editor_out;
  ast_pkg::pattern_t          pattern_out;
  logic                       disarm;
  logic                       is_editor;

  assign advance    = tick_valid & (~result.valid | result.ready);
  assign tick.ready = ~tick_valid | advance;
  assign is_editor  = (tick_q.op == ast_pkg::OP_EDITOR);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      hour_mode  <= 1'b0;
      beat_limit <= ast_pkg::BeatLimitReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ast_pkg::CFG_HOUR_MODE:  hour_mode  <= cfg_data[0];
        ast_pkg::CFG_BEAT_LIMIT: beat_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // tick register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (tick.ready) begin
      tick_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      tick_q.op           <= ast_pkg::op_t'(tick.operation);
      tick_q.buttons      <= '{left:  tick.left_pressed,  right: tick.right_pressed,
                               up:    tick.up_pressed,    down:  tick.down_pressed,
                               req:   tick.edit_request};
      tick_q.heartbeat    <= tick.heartbeat;
      tick_q.clock_hour   <= tick.clock_hour;
      tick_q.clock_minute <= tick.clock_minute;
    end
  end

  ast_editor u_editor (
    .cur       (edit),
    .buttons   (tick_q.buttons),
    .hour_mode (hour_mode),
    .nxt       (editor_out)
  );

  ast_pattern u_pattern (
    .cur          (pattern),
    .armed        (armed),
    .heartbeat    (tick_q.heartbeat),
    .clock_hour   (tick_q.clock_hour),
    .clock_minute (tick_q.clock_minute),
    .beat_limit   (beat_limit),
    .nxt          (pattern_out),
    .disarm       (disarm)
  );

  always_comb begin
    edit_next    = edit;
    armed_next   = armed;
    pattern_next = pattern;
    if (is_editor) begin
      edit_next = editor_out;
      if (editor_out.state == ast_pkg::E_COMMIT) begin
        armed_next = '{flag: 1'b1, hour: edit.hour, minute: edit.minute, pm: edit.pm};
      end
    end else begin
      pattern_next = pattern_out;
      if (disarm) armed_next.flag = 1'b0;
    end
  end

  // block state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      edit         <= '{state: ast_pkg::E_INIT, hour: '0, minute: '0, pm: 1'b0};
      armed        <= '0;
      pattern      <= '{state: ast_pkg::P_INIT, beat: '0};
      result.valid <= 1'b0;
    end else begin
      if (advance) begin
        edit         <= edit_next;
        armed        <= armed_next;
        pattern      <= pattern_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.editor_phase <= edit_next.state;
      result.edit_hour    <= edit_next.hour;
      result.edit_minute  <= edit_next.minute;
      result.edit_pm      <= edit_next.pm;
      result.alarm_armed  <= armed_next.flag;
      result.armed_hour   <= armed_next.hour;
      result.armed_minute <= armed_next.minute;
      result.armed_pm     <= armed_next.pm;
      result.buzzer_on    <= (pattern_next.state == ast_pkg::P_ON);
      result.committed    <= is_editor & (edit_next.state == ast_pkg::E_COMMIT);
      result.cancelled    <= is_editor & (edit_next.state == ast_pkg::E_CANCEL);
    end
  end

endmodule

// ===== hdl/ast_checker.sv =====
// ----------------------------------------------------------------------------
// ast_checker
// port-level checks on the alarm set and trigger top, attached by bind
// ----------------------------------------------------------------------------
`include "alarm_set_and_trigger_top_macros.svh"

module ast_checker (
  input logic       clk,
  input logic       rst,
  input logic       tick_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [3:0] editor_phase,
  input logic       alarm_armed,
  input logic       buzzer_on,
  input logic       committed,
  input logic       cancelled
);

  // a stalled result item holds
  `AST_ASSERT_NXT(a_result_hold, result_valid && !result_ready,
                  result_valid && $stable(editor_phase) && $stable(alarm_armed))

  // an empty output side never blocks the input
  `AST_ASSERT_IMP(a_ready_when_free, !result_valid, tick_ready)

  // a commit arms the alarm and reports the commit phase
  `AST_ASSERT_IMP(a_commit_arms, result_valid && committed,
                  alarm_armed && !cancelled && editor_phase == ast_pkg::E_COMMIT)

  // the buzzer only sounds for an armed alarm
  `AST_ASSERT_IMP(a_buzz_armed, result_valid && buzzer_on, alarm_armed)

endmodule

bind alarm_set_and_trigger_top ast_checker u_ast_checker (
  .clk          (clk),
  .rst          (rst),
  .tick_ready   (tick.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .editor_phase (result.editor_phase),
  .alarm_armed  (result.alarm_armed),
  .buzzer_on    (result.buzzer_on),
  .committed    (result.committed),
  .cancelled    (result.cancelled)
);

// ===== tb/alarm_set_and_trigger_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_set_and_trigger_top_test
// editor and alarm tick items with a predictor for every result item
// directed walk through one edit session, commit, alarm match, stop and cancel,
// then random edit sessions with alarm ticks near the armed time, register
// changes between phases, idle gaps on the input and stalls on the result
// ----------------------------------------------------------------------------
module alarm_set_and_trigger_top_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 225;
  localparam int MAX_REPORTS = 100;

  localparam ast_pkg::buttons_t NO_BTN = 5'b00000;
  localparam ast_pkg::buttons_t BTN_L  = 5'b10000;
  localparam ast_pkg::buttons_t BTN_R  = 5'b01000;
  localparam ast_pkg::buttons_t BTN_U  = 5'b00100;
  localparam ast_pkg::buttons_t BTN_D  = 5'b00010;
  localparam ast_pkg::buttons_t BTN_Q  = 5'b00001;

  typedef struct packed {
    ast_pkg::edit_t  edit;
    ast_pkg::armed_t alarm;
    logic            buzz;
    logic            commit;
    logic            cancel;
  } result_t;

  typedef struct {
    bit             is_cfg;
    logic           mode;
    logic [3:0]     lim;
    ast_pkg::tick_t t;
    bit             fixed;
    result_t        want;
  } plan_row_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [3:0] cfg_data;

  ast_tick_if   tick_ch ();
  ast_result_if result_ch ();

  alarm_set_and_trigger_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .result    (result_ch)
  );

  // predicted block state and registers
  ast_pkg::edit_t    ed;
  ast_pkg::armed_t   alm;
  ast_pkg::pattern_t pat;
  logic              mode_24;
  logic [3:0]        beat_lim;

  result_t outcomes_due [$];
  plan_row_t plan [$];

  logic       mode_seq [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  logic [3:0] lim_seq  [6] = '{4'd15, 4'd0, 4'd0, 4'd15, 4'd6, 4'd3};

  int  errors = 0;
  int  cycles = 0;
  int  n_ticks = 0;
  int  n_alarm = 0;
  int  n_commit = 0;
  int  n_cancel = 0;
  int  n_buzz = 0;
  int  n_cfg = 0;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;
  bit  sending = 1'b0;
  bit  sess_up = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t run did not complete within %0d cycles", $time, CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic ast_pkg::editor_state_t pick_move(ast_pkg::buttons_t b,
                                                       ast_pkg::editor_state_t stay,
                                                       ast_pkg::editor_state_t on_l,
                                                       ast_pkg::editor_state_t on_r,
                                                       ast_pkg::editor_state_t on_u,
                                                       ast_pkg::editor_state_t on_d);
    if (b.left && !b.right && !b.up && !b.down) return on_l;
    if (b.right && !b.left && !b.up && !b.down) return on_r;
    if (b.up && !b.left && !b.right && !b.down) return on_u;
    if (b.down && !b.left && !b.right && !b.up) return on_d;
    return stay;
  endfunction

  // advance the predicted state by one tick and return the result item it gives
  function automatic result_t tick_outcome(ast_pkg::tick_t t);
    ast_pkg::editor_state_t  nxt;
    ast_pkg::pattern_state_t pn;
    result_t                 r;
    if (t.op == ast_pkg::OP_EDITOR) begin
      case (ed.state)
        ast_pkg::E_INIT:    nxt = ast_pkg::E_WAIT;
        ast_pkg::E_WAIT:    nxt = t.buttons.req ? ast_pkg::E_BWAIT : ast_pkg::E_WAIT;
        ast_pkg::E_BWAIT:   nxt = (t.buttons.left || t.buttons.right) ? ast_pkg::E_BWAIT
                                                                      : ast_pkg::E_FIELD_H;
        ast_pkg::E_SHOW_H:  nxt = ast_pkg::E_FIELD_H;
        ast_pkg::E_FIELD_H: nxt = pick_move(t.buttons, ast_pkg::E_FIELD_H, ast_pkg::E_SHOW_M,
                                            ast_pkg::E_CANCEL, ast_pkg::E_INC_H,
                                            ast_pkg::E_DEC_H);
        ast_pkg::E_INC_H, ast_pkg::E_DEC_H: nxt = ast_pkg::E_SHOW_H;
        ast_pkg::E_SHOW_M:  nxt = ast_pkg::E_FIELD_M;
        ast_pkg::E_FIELD_M: nxt = pick_move(t.buttons, ast_pkg::E_FIELD_M,
                                            mode_24 ? ast_pkg::E_COMMIT : ast_pkg::E_SHOW_P,
                                            ast_pkg::E_SHOW_H, ast_pkg::E_INC_M,
                                            ast_pkg::E_DEC_M);
        ast_pkg::E_INC_M, ast_pkg::E_DEC_M: nxt = ast_pkg::E_SHOW_M;
        ast_pkg::E_SHOW_P:  nxt = ast_pkg::E_FIELD_P;
        ast_pkg::E_FIELD_P: begin
          // up and down together still toggle the half of day
          if ((t.buttons.up || t.buttons.down) && !t.buttons.left && !t.buttons.right)
            nxt = ast_pkg::E_TOGGLE_P;
          else
            nxt = pick_move(t.buttons, ast_pkg::E_FIELD_P, ast_pkg::E_COMMIT,
                            ast_pkg::E_SHOW_M, ast_pkg::E_FIELD_P, ast_pkg::E_FIELD_P);
        end
        ast_pkg::E_TOGGLE_P: nxt = ast_pkg::E_SHOW_P;
        default:   nxt = ast_pkg::E_WAIT;
      endcase
      case (nxt)
        ast_pkg::E_BWAIT: begin
          ed.hour = ast_pkg::HourMax12;
          ed.minute = '0;
          ed.pm = 1'b0;
        end
        ast_pkg::E_INC_H: begin
          ed.hour = ed.hour + 1'b1;
          if (mode_24 && ed.hour > ast_pkg::HourMax24) ed.hour = '0;
          else if (!mode_24 && ed.hour > ast_pkg::HourMax12) ed.hour = 5'd1;
        end
        ast_pkg::E_DEC_H: begin
          if (mode_24 && ed.hour == '0) ed.hour = ast_pkg::HourMax24;
          else if (!mode_24 && ed.hour <= 5'd1) ed.hour = ast_pkg::HourMax12;
          else ed.hour = ed.hour - 1'b1;
        end
        ast_pkg::E_INC_M: begin
          ed.minute = ed.minute + 1'b1;
          if (ed.minute > ast_pkg::MinuteMax) ed.minute = '0;
        end
        ast_pkg::E_DEC_M: begin
          if (ed.minute == '0) ed.minute = ast_pkg::MinuteMax;
          else ed.minute = ed.minute - 1'b1;
        end
        ast_pkg::E_TOGGLE_P: ed.pm = ~ed.pm;
        ast_pkg::E_COMMIT: alm = '{1'b1, ed.hour, ed.minute, ed.pm};
        default: ;
      endcase
      ed.state = nxt;
    end else begin
      case (pat.state)
        ast_pkg::P_INIT: pn = ast_pkg::P_WAIT;
        ast_pkg::P_WAIT: begin
          // half of day is not part of the match
          if (alm.flag && alm.hour == t.clock_hour && alm.minute == t.clock_minute) begin
            pn = ast_pkg::P_ON;
            pat.beat = '0;
          end else begin
            pn = ast_pkg::P_WAIT;
          end
        end
        ast_pkg::P_ON, ast_pkg::P_OFF: begin
          if (t.heartbeat && pat.beat != ast_pkg::BeatMax) pat.beat = pat.beat + 1'b1;
          if (pat.beat > beat_lim) pn = ast_pkg::P_STOP;
          else pn = (pat.state == ast_pkg::P_ON) ? ast_pkg::P_OFF : ast_pkg::P_ON;
        end
        default: pn = ast_pkg::P_INIT;
      endcase
      if (pn == ast_pkg::P_STOP) alm.flag = 1'b0;
      pat.state = pn;
    end
    r.edit = ed;
    r.alarm = alm;
    r.buzz = (pat.state == ast_pkg::P_ON);
    r.commit = (t.op == ast_pkg::OP_EDITOR) && (ed.state == ast_pkg::E_COMMIT);
    r.cancel = (t.op == ast_pkg::OP_EDITOR) && (ed.state == ast_pkg::E_CANCEL);
    return r;
  endfunction

  // button levels that mostly make progress through an edit session
  function automatic ast_pkg::buttons_t steer_buttons();
    ast_pkg::buttons_t b;
    int                pct;
    bit                go_up;
    b = '0;
    b.req = 1'($urandom_range(0, 1));
    pct = $urandom_range(0, 99);
    case (ed.state)
      ast_pkg::E_INIT, ast_pkg::E_WAIT, ast_pkg::E_COMMIT, ast_pkg::E_CANCEL:
        b.req = (pct < 70);
      ast_pkg::E_BWAIT: begin
        b.left = (pct < 20);
        b.right = (pct >= 85);
        sess_up = 1'($urandom_range(0, 1));
      end
      ast_pkg::E_FIELD_H, ast_pkg::E_FIELD_M: begin
        if (pct < 80) begin
          go_up = ($urandom_range(0, 9) < 8) ? sess_up : !sess_up;
          b.up = go_up;
          b.down = !go_up;
        end else if (pct < 93) begin
          b.left = 1'b1;
        end else if (pct < 97) begin
          b.right = 1'b1;
        end
      end
      ast_pkg::E_FIELD_P: begin
        if (pct < 20) b.up = 1'b1;
        else if (pct < 30) b.down = 1'b1;
        else if (pct < 40) begin
          b.up = 1'b1;
          b.down = 1'b1;
        end else if (pct < 95) b.left = 1'b1;
        else b.right = 1'b1;
      end
      default: if (pct < 30) b = 5'($urandom_range(0, 31));
    endcase
    return b;
  endfunction

  function automatic ast_pkg::tick_t make_tick();
    ast_pkg::tick_t t;
    int             alarm_pct;
    int             pct;
    t.op = ast_pkg::OP_EDITOR;
    t.buttons = 5'($urandom_range(0, 31));
    t.heartbeat = 1'($urandom_range(0, 1));
    t.clock_hour = 5'($urandom_range(0, 31));
    t.clock_minute = 6'($urandom_range(0, 63));
    if (ed.state == ast_pkg::E_INIT || ed.state == ast_pkg::E_WAIT ||
        ed.state == ast_pkg::E_COMMIT || ed.state == ast_pkg::E_CANCEL)
      alarm_pct = 45;
    else
      alarm_pct = 12;
    if (pat.state == ast_pkg::P_ON || pat.state == ast_pkg::P_OFF) alarm_pct = 70;
    if ($urandom_range(0, 99) < alarm_pct) begin
      t.op = ast_pkg::OP_ALARM;
      pct = $urandom_range(0, 99);
      if (alm.flag && pct < 60) begin
        t.clock_hour = alm.hour;
        t.clock_minute = alm.minute;
      end else if (pct < 85) begin
        t.clock_hour = 5'($urandom_range(0, 23));
        t.clock_minute = 6'($urandom_range(0, 59));
      end
    end else if ($urandom_range(0, 99) >= 8) begin
      t.buttons = steer_buttons();
    end
    return t;
  endfunction

  function automatic plan_row_t tick_row(ast_pkg::op_t op, ast_pkg::buttons_t b, logic hb,
                                         logic [4:0] h, logic [5:0] m);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.mode = 1'b0;
    row.lim = '0;
    row.t.op = op;
    row.t.buttons = b;
    row.t.heartbeat = hb;
    row.t.clock_hour = h;
    row.t.clock_minute = m;
    row.fixed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(logic mode, logic [3:0] lim);
    plan_row_t row;
    row = tick_row(ast_pkg::OP_EDITOR, NO_BTN, 1'b0, '0, '0);
    row.is_cfg = 1'b1;
    row.mode = mode;
    row.lim = lim;
    return row;
  endfunction

  // editor rows whose result is all zero apart from the phase and the hour
  function automatic plan_row_t pinned(plan_row_t row, ast_pkg::editor_state_t ph,
                                       logic [4:0] hr);
    row.fixed = 1'b1;
    row.want = '0;
    row.want.edit.state = ph;
    row.want.edit.hour = hr;
    return row;
  endfunction

  task automatic send_tick(ast_pkg::tick_t t, bit fixed, result_t want);
    result_t r;
    if (burst_left == 0) begin
      if (gaps_on) begin
        if (sending) begin
          tick_ch.valid <= 1'b0;
          sending = 1'b0;
        end
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    tick_ch.valid         <= 1'b1;
    tick_ch.operation     <= t.op;
    tick_ch.left_pressed  <= t.buttons.left;
    tick_ch.right_pressed <= t.buttons.right;
    tick_ch.up_pressed    <= t.buttons.up;
    tick_ch.down_pressed  <= t.buttons.down;
    tick_ch.edit_request  <= t.buttons.req;
    tick_ch.heartbeat     <= t.heartbeat;
    tick_ch.clock_hour    <= t.clock_hour;
    tick_ch.clock_minute  <= t.clock_minute;
    sending = 1'b1;
    do @(posedge clk); while (!tick_ch.ready);
    r = tick_outcome(t);
    outcomes_due.push_back(fixed ? want : r);
    n_ticks++;
    if (t.op == ast_pkg::OP_ALARM) n_alarm++;
  endtask

  task automatic wait_drained();
    if (sending) begin
      tick_ch.valid <= 1'b0;
      sending = 1'b0;
    end
    do @(posedge clk); while (outcomes_due.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_config(logic mode, logic [3:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= ast_pkg::CFG_HOUR_MODE;
    cfg_data  <= {3'b000, mode};
    @(posedge clk);
    cfg_index <= ast_pkg::CFG_BEAT_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_24 = mode;
    beat_lim = lim;
    n_cfg++;
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (outcomes_due.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t result item with nothing expected, phase %0d", $time,
                 result_ch.editor_phase);
      return;
    end
    want = outcomes_due.pop_front();
    check_field("editor_phase", 8'(want.edit.state), 8'(result_ch.editor_phase));
    check_field("edit_hour", 8'(want.edit.hour), 8'(result_ch.edit_hour));
    check_field("edit_minute", 8'(want.edit.minute), 8'(result_ch.edit_minute));
    check_field("edit_pm", 8'(want.edit.pm), 8'(result_ch.edit_pm));
    check_field("alarm_armed", 8'(want.alarm.flag), 8'(result_ch.alarm_armed));
    check_field("armed_hour", 8'(want.alarm.hour), 8'(result_ch.armed_hour));
    check_field("armed_minute", 8'(want.alarm.minute), 8'(result_ch.armed_minute));
    check_field("armed_pm", 8'(want.alarm.pm), 8'(result_ch.armed_pm));
    check_field("buzzer_on", 8'(want.buzz), 8'(result_ch.buzzer_on));
    check_field("committed", 8'(want.commit), 8'(result_ch.committed));
    check_field("cancelled", 8'(want.cancel), 8'(result_ch.cancelled));
    if (result_ch.committed === 1'b1) n_commit++;
    if (result_ch.cancelled === 1'b1) n_cancel++;
    if (result_ch.buzzer_on === 1'b1) n_buzz++;
  endtask

  // result side: checks each accepted result item and drives ready in randomly chosen stall modes
  initial begin
    int stall_mode;
    int mode_left;
    int hold;
    stall_mode = 0;
    mode_left = 0;
    hold = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) check_result();
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(40, 300);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: result_ch.ready <= 1'b1;
        1: result_ch.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (hold > 0) begin
            hold--;
            result_ch.ready <= 1'b0;
          end else begin
            result_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) hold = $urandom_range(1, 8);
          end
        end
      endcase
    end
  end

  initial begin
    int hold_at;
    tick_ch.valid         <= 1'b0;
    tick_ch.operation     <= ast_pkg::OP_EDITOR;
    tick_ch.left_pressed  <= 1'b0;
    tick_ch.right_pressed <= 1'b0;
    tick_ch.up_pressed    <= 1'b0;
    tick_ch.down_pressed  <= 1'b0;
    tick_ch.edit_request  <= 1'b0;
    tick_ch.heartbeat     <= 1'b0;
    tick_ch.clock_hour    <= '0;
    tick_ch.clock_minute  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= ast_pkg::CFG_HOUR_MODE;
    cfg_data  <= '0;
    rst       <= 1'b1;
    ed = '{ast_pkg::E_INIT, 5'd0, 6'd0, 1'b0};
    alm = '0;
    pat = '{ast_pkg::P_INIT, 4'd0};
    mode_24 = 1'b0;
    beat_lim = ast_pkg::BeatLimitReset;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one twelve-hour session: hour wraps both ways, minute wraps both ways,
    // several buttons at once, am/pm toggle with up and down together
    plan.push_back(pinned(tick_row(ast_pkg::OP_EDITOR, NO_BTN, 1'b0, '0, '0),
                          ast_pkg::E_WAIT, 5'd0));
    plan.push_back(pinned(tick_row(ast_pkg::OP_EDITOR, BTN_Q, 1'b0, '0, '0),
                          ast_pkg::E_BWAIT, ast_pkg::HourMax12));
    plan.push_back(pinned(tick_row(ast_pkg::OP_EDITOR, BTN_L | BTN_Q, 1'b0, '0, '0),
                          ast_pkg::E_BWAIT, ast_pkg::HourMax12));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, NO_BTN, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, BTN_U, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, NO_BTN, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, NO_BTN, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, BTN_D, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, BTN_L | BTN_R | BTN_U | BTN_D, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, BTN_L | BTN_U, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, BTN_L | BTN_U, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, BTN_L, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, NO_BTN, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, BTN_D, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, NO_BTN, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, NO_BTN, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, BTN_U, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, NO_BTN, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, NO_BTN, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, BTN_L, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, NO_BTN, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, BTN_U | BTN_D, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, NO_BTN, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, NO_BTN, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, BTN_L | BTN_Q, 1'b0, '0, '0));
    // alarm at 12:00, then stop with the beat limit at zero
    plan.push_back(tick_row(ast_pkg::OP_ALARM, NO_BTN, 1'b0, 5'd12, 6'd0));
    plan.push_back(tick_row(ast_pkg::OP_ALARM, NO_BTN, 1'b1, 5'd12, 6'd0));
    plan.push_back(tick_row(ast_pkg::OP_ALARM, BTN_L | BTN_R | BTN_U | BTN_D | BTN_Q, 1'b1,
                            5'd31, 6'd63));
    plan.push_back(cfg_row(1'b1, 4'd0));
    plan.push_back(tick_row(ast_pkg::OP_ALARM, NO_BTN, 1'b1, 5'd0, 6'd0));
    // edit request still held after commit, then cancel from the hour field
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, BTN_Q, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, BTN_Q, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, BTN_R, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, NO_BTN, 1'b0, '0, '0));
    plan.push_back(tick_row(ast_pkg::OP_EDITOR, BTN_R, 1'b0, '0, '0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drained();
        set_config(plan[i].mode, plan[i].lim);
      end else begin
        send_tick(plan[i].t, plan[i].fixed, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      if (ph < 6) set_config(mode_seq[ph], lim_seq[ph]);
      else set_config(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      gaps_on = (ph % 3) != 1;
      hold_at = $urandom_range(20, 200);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == hold_at) wait_drained();
        send_tick(make_tick(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (outcomes_due.size() != 0) begin
      errors++;
      $display("%0t %0d result items never arrived", $time, outcomes_due.size());
    end
    $display("covered %0d ticks (%0d alarm ticks): %0d commits, %0d cancels, %0d buzzing",
             n_ticks, n_alarm, n_commit, n_cancel, n_buzz);
    $display("register settings applied: %0d, mismatches: %0d", n_cfg, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ast_pkg.sv
hdl/ast_if.sv
hdl/ast_editor.sv
hdl/ast_pattern.sv
hdl/alarm_set_and_trigger_top.sv
hdl/ast_checker.sv
tb/alarm_set_and_trigger_top_test.sv
